@@ hdl/pmmu_pkg.sv @@
package pmmu_pkg;

   // field and port widths
   localparam int ADDR_W   = 16;
   localparam int OFFSET_W = 12;
   localparam int VPN_W    = 4;
   localparam int FRAME_W  = 8;
   localparam int PHYS_W   = 20;
   localparam int FCOUNT_W = 5;
   localparam int CSR_AW   = 4;
   localparam int CSR_DW   = 32;

   // register indexes on the csr port
   localparam logic [1:0] REG_LRU_MODE    = 2'd0;
   localparam logic [1:0] REG_FRAME_COUNT = 2'd1;
   localparam logic [1:0] REG_FIRST_FRAME = 2'd2;

   // register reset values
   localparam logic                RST_LRU_MODE    = 1'b0;
   localparam logic [FCOUNT_W-1:0] RST_FRAME_COUNT = 5'd16;
   localparam logic [FRAME_W-1:0]  RST_FIRST_FRAME = 8'd64;

   typedef struct packed {
      logic [ADDR_W-1:0] logical_address;
      logic              req_type;
   } req_word_type;

   typedef struct packed {
      logic              fault;
      logic              dirty_evict;
      logic [PHYS_W-1:0] physical_address;
   } rsp_word_type;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic exec;
      logic load;
      logic evict;
      logic hit_move;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic hit;
      logic full;
      logic lru;
   } status_type;

endpackage

@@ hdl/pmmu_ram.sv @@
module pmmu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/pmmu_ctrl.sv @@
module pmmu_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  pmmu_pkg::status_type  status,
   output pmmu_pkg::cmd_type     cmd
);

   pmmu_pkg::state_type state_ff;
   pmmu_pkg::state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pmmu_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      case (state_ff)
         pmmu_pkg::ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = pmmu_pkg::ST_EXEC;
            end
         end
         pmmu_pkg::ST_EXEC: begin
            cmd.exec     = 1'b1;
            cmd.load     = !status.hit;
            cmd.evict    = !status.hit && status.full;
            cmd.hit_move = status.hit && status.lru;
            state_in     = pmmu_pkg::ST_IDLE;
         end
         default: begin
            state_in = pmmu_pkg::ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff == pmmu_pkg::ST_EXEC);

   // the update step is always followed by a return to idle
   a_exec_once: assert property (@(posedge clock) disable iff (reset)
      state_ff == pmmu_pkg::ST_EXEC |=> state_ff == pmmu_pkg::ST_IDLE)
      else $error("update step held longer than one cycle");

   // a reference is only captured while idle, and the update step follows each capture
   a_capture_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> cmd.exec)
      else $error("capture not followed by update step");

endmodule

@@ hdl/pmmu_dp.sv @@
module pmmu_dp #(
   parameter int PAGE_COUNT = 16,
   parameter int MAX_FRAMES = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  pmmu_pkg::cmd_type                    cmd,
   output pmmu_pkg::status_type                 status,
   input  logic                                 lru_mode,
   input  logic [$clog2(MAX_FRAMES+1)-1:0]      pool_n,
   input  logic                                 reinit,
   input  logic [pmmu_pkg::FRAME_W-1:0]         reinit_first,
   input  pmmu_pkg::req_word_type               req_data,
   output logic                                 rsp_valid,
   output pmmu_pkg::rsp_word_type               rsp_data
);

   localparam int PW = $clog2(PAGE_COUNT);
   localparam int SW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam int NW = $clog2(MAX_FRAMES + 1);
   localparam int VPN_COUNT = 1 << pmmu_pkg::VPN_W;
   localparam int FW = pmmu_pkg::FRAME_W;

   // page number folding into the table
   logic [PW-1:0] page_map [VPN_COUNT];
   logic [PW-1:0] req_page;

   for (genvar g = 0; g < VPN_COUNT; g++) begin : g_page_map
      assign page_map[g] = PW'(g % PAGE_COUNT);
   end

   assign req_page = page_map[req_data.logical_address[pmmu_pkg::ADDR_W-1 -: pmmu_pkg::VPN_W]];

   // captured reference
   logic [pmmu_pkg::OFFSET_W-1:0] offset_ff;
   logic                          write_ff;
   logic [PW-1:0]                 page_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         offset_ff <= req_data.logical_address[pmmu_pkg::OFFSET_W-1:0];
         write_ff  <= req_data.req_type;
         page_ff   <= req_page;
      end
   end

   // page table marks, frame order queue and per page queue slot
   logic [PAGE_COUNT-1:0] valid_ff, valid_in;
   logic [PAGE_COUNT-1:0] mod_ff, mod_in;
   logic [SW-1:0]         pos_ff [PAGE_COUNT];
   logic [SW-1:0]         pos_in [PAGE_COUNT];
   logic [FW-1:0]         slot_frame_ff [MAX_FRAMES];
   logic [FW-1:0]         slot_frame_in [MAX_FRAMES];
   logic [PW-1:0]         slot_page_ff [MAX_FRAMES];
   logic [PW-1:0]         slot_page_in [MAX_FRAMES];
   logic [NW-1:0]         used_ff, used_in;
   logic                  rsp_valid_ff;
   pmmu_pkg::rsp_word_type rsp_data_ff;

   logic [FW-1:0] frame_rd;
   logic          hit;
   logic          full;
   logic          shift_en;
   logic [SW-1:0] k;
   logic [SW-1:0] last;
   logic [PW-1:0] victim;
   logic [FW-1:0] v_frame;
   logic          wb;

   // page to frame store
   pmmu_ram #(
      .WIDTH (FW),
      .DEPTH (PAGE_COUNT)
   ) u_frame_ram (
      .clock   (clock),
      .wr_en   (cmd.exec && cmd.load),
      .wr_addr (page_ff),
      .wr_data (slot_frame_ff[0]),
      .rd_en   (cmd.capture),
      .rd_addr (req_page),
      .rd_data (frame_rd)
   );

   // lookup status
   assign hit    = valid_ff[page_ff];
   assign full   = (used_ff == pool_n);
   assign status = '{hit: hit, full: full, lru: lru_mode};

   // move-to-back control: a load takes the head, a hit takes its own slot
   assign shift_en = cmd.exec && (cmd.load || cmd.hit_move);
   assign k        = cmd.load ? '0 : pos_ff[page_ff];
   assign last     = SW'(pool_n - NW'(1));
   assign victim   = slot_page_ff[0];
   assign v_frame  = cmd.load ? slot_frame_ff[0] : frame_rd;
   assign wb       = cmd.evict && mod_ff[victim];

   // queue slots shift left over [k, last) and the moved frame lands at last
   always_comb begin
      for (int i = 0; i < MAX_FRAMES; i++) begin
         slot_frame_in[i] = slot_frame_ff[i];
         slot_page_in[i]  = slot_page_ff[i];
         if (reinit) begin
            slot_frame_in[i] = FW'(int'(reinit_first) + i);
         end else if (shift_en) begin
            if (i == int'(last)) begin
               slot_frame_in[i] = v_frame;
               slot_page_in[i]  = page_ff;
            end else if (i >= int'(k) && i < int'(last)) begin
               slot_frame_in[i] = slot_frame_ff[(i < MAX_FRAMES - 1) ? i + 1 : i];
               slot_page_in[i]  = slot_page_ff[(i < MAX_FRAMES - 1) ? i + 1 : i];
            end
         end
      end
   end

   // slot of each page follows the queue shift
   always_comb begin
      for (int p = 0; p < PAGE_COUNT; p++) begin
         pos_in[p] = pos_ff[p];
         if (shift_en) begin
            if (p == int'(page_ff)) begin
               pos_in[p] = last;
            end else if (pos_ff[p] > k) begin
               pos_in[p] = pos_ff[p] - SW'(1);
            end
         end
      end
   end

   // valid and modified marks, frames in use
   always_comb begin
      valid_in = valid_ff;
      mod_in   = mod_ff;
      used_in  = used_ff;
      if (reinit) begin
         valid_in = '0;
         mod_in   = '0;
         used_in  = '0;
      end else if (cmd.exec) begin
         if (cmd.evict) begin
            valid_in[victim] = 1'b0;
         end
         if (cmd.load) begin
            valid_in[page_ff] = 1'b1;
            mod_in[page_ff]   = write_ff;
            if (!full) begin
               used_in = used_ff + NW'(1);
            end
         end else begin
            mod_in[page_ff] = mod_ff[page_ff] | write_ff;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         mod_ff       <= '0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_FRAMES; i++) begin
            slot_frame_ff[i] <= FW'(int'(pmmu_pkg::RST_FIRST_FRAME) + i);
         end
      end else begin
         valid_ff      <= valid_in;
         mod_ff        <= mod_in;
         used_ff       <= used_in;
         rsp_valid_ff  <= cmd.exec;
         slot_frame_ff <= slot_frame_in;
      end
   end

   // payload state
   always_ff @(posedge clock) begin
      slot_page_ff <= slot_page_in;
      pos_ff       <= pos_in;
      if (cmd.exec) begin
         rsp_data_ff.fault            <= cmd.load;
         rsp_data_ff.dirty_evict      <= wb;
         rsp_data_ff.physical_address <= {v_frame, offset_ff};
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // frames in use never pass the pool size
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= pool_n)
      else $error("frames in use exceed pool size");

   // the head frame always belongs to a resident page when the pool is full
   a_victim_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.exec && cmd.evict |-> valid_ff[victim])
      else $error("eviction of a page that is not resident");

   // write-back only comes with a page fault
   a_wb_fault: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.fault || !rsp_data_ff.dirty_evict))
      else $error("write-back on a hit");

endmodule

@@ hdl/paging_mmu_fifo_lru_replacement.sv @@
// result path: the edge that takes start captures the reference and enters the update
//   step; rsp_valid and the result word are registered at the end of that step
// a new reference is taken only after the update step, while busy is low; each
//   reference is a registered read of the page-to-frame store, then the update step
// the receiver cannot stall: each result is shown for exactly one cycle
// reset (synchronous, active high): page table empty, queue rebuilt from
//   first frame 64, FIFO policy, 16 frames
module paging_mmu_fifo_lru_replacement #(
   parameter int PAGE_COUNT = 16,
   parameter int MAX_FRAMES = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  pmmu_pkg::req_word_type        req_data,
   output logic                          rsp_valid,
   output pmmu_pkg::rsp_word_type        rsp_data,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [pmmu_pkg::CSR_AW-1:0]   paddr,
   input  logic [pmmu_pkg::CSR_DW-1:0]   pwdata,
   output logic [pmmu_pkg::CSR_DW-1:0]   prdata,
   output logic                          pready
);

   localparam int NW = $clog2(MAX_FRAMES + 1);

   logic                            lru_ff, lru_in;
   logic [pmmu_pkg::FCOUNT_W-1:0]   fcount_ff, fcount_in;
   logic [pmmu_pkg::FRAME_W-1:0]    first_ff, first_in;
   logic                            csr_wr;
   logic [1:0]                      csr_idx;
   logic                            reinit;
   logic [NW-1:0]                   pool_n;
   pmmu_pkg::cmd_type               cmd;
   pmmu_pkg::status_type            status;

   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite;
   assign csr_idx = paddr[3:2];

   // register writes
   always_comb begin
      lru_in    = lru_ff;
      fcount_in = fcount_ff;
      first_in  = first_ff;
      reinit    = 1'b0;
      if (csr_wr) begin
         case (csr_idx)
            pmmu_pkg::REG_LRU_MODE: begin
               lru_in = pwdata[0];
            end
            pmmu_pkg::REG_FRAME_COUNT: begin
               fcount_in = pwdata[pmmu_pkg::FCOUNT_W-1:0];
               reinit    = 1'b1;
            end
            pmmu_pkg::REG_FIRST_FRAME: begin
               first_in = pwdata[pmmu_pkg::FRAME_W-1:0];
               reinit   = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lru_ff    <= pmmu_pkg::RST_LRU_MODE;
         fcount_ff <= pmmu_pkg::RST_FRAME_COUNT;
         first_ff  <= pmmu_pkg::RST_FIRST_FRAME;
      end else begin
         lru_ff    <= lru_in;
         fcount_ff <= fcount_in;
         first_ff  <= first_in;
      end
   end

   // register reads
   always_comb begin
      case (csr_idx)
         pmmu_pkg::REG_LRU_MODE:    prdata = pmmu_pkg::CSR_DW'(lru_ff);
         pmmu_pkg::REG_FRAME_COUNT: prdata = pmmu_pkg::CSR_DW'(fcount_ff);
         pmmu_pkg::REG_FIRST_FRAME: prdata = pmmu_pkg::CSR_DW'(first_ff);
         default:                   prdata = '0;
      endcase
   end

   // pool size: zero acts as one, clipped to the queue depth
   always_comb begin
      if (fcount_ff == '0) begin
         pool_n = NW'(1);
      end else if (int'(fcount_ff) > MAX_FRAMES) begin
         pool_n = NW'(MAX_FRAMES);
      end else begin
         pool_n = NW'(fcount_ff);
      end
   end

   pmmu_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   pmmu_dp #(
      .PAGE_COUNT (PAGE_COUNT),
      .MAX_FRAMES (MAX_FRAMES)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .lru_mode     (lru_ff),
      .pool_n       (pool_n),
      .reinit       (reinit),
      .reinit_first (first_in),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_data     (rsp_data)
   );

endmodule

@@ test/tb_paging_mmu_fifo_lru_replacement.sv @@
`timescale 1ns / 100ps

module tb_paging_mmu_fifo_lru_replacement;

   localparam int NUM_PAGES  = 16;
   localparam int NUM_FRAMES = 16;

   // access kinds
   localparam logic REQ_READ  = 1'b0;
   localparam logic REQ_WRITE = 1'b1;

   // csr byte addresses
   localparam logic [pmmu_pkg::CSR_AW-1:0] ADDR_LRU_MODE    = {pmmu_pkg::REG_LRU_MODE, 2'b00};
   localparam logic [pmmu_pkg::CSR_AW-1:0] ADDR_FRAME_COUNT =
      {pmmu_pkg::REG_FRAME_COUNT, 2'b00};
   localparam logic [pmmu_pkg::CSR_AW-1:0] ADDR_FIRST_FRAME =
      {pmmu_pkg::REG_FIRST_FRAME, 2'b00};
   localparam logic [pmmu_pkg::CSR_AW-1:0] ADDR_UNMAPPED    = 4'd12;

   localparam int RAND_PHASES    = 8;
   localparam int REFS_PER_PHASE = 190;

   typedef enum logic {ROW_REF, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type                    kind;
      logic [pmmu_pkg::CSR_AW-1:0]     csr_addr;
      logic [pmmu_pkg::CSR_DW-1:0]     csr_value;
      pmmu_pkg::req_word_type          word;
      logic                            typed;
      pmmu_pkg::rsp_word_type          want;
   } stim_row_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          start = 1'b0;
   logic                          busy;
   pmmu_pkg::req_word_type        req_data = '0;
   logic                          rsp_valid;
   pmmu_pkg::rsp_word_type        rsp_data;
   logic                          psel = 1'b0;
   logic                          penable = 1'b0;
   logic                          pwrite = 1'b0;
   logic [pmmu_pkg::CSR_AW-1:0]   paddr = '0;
   logic [pmmu_pkg::CSR_DW-1:0]   pwdata = '0;
   logic [pmmu_pkg::CSR_DW-1:0]   prdata;
   logic                          pready;

   paging_mmu_fifo_lru_replacement dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always #6 clock = ~clock;

   // shadow page table, frame queue and pool settings
   logic                          pt_valid [NUM_PAGES];
   logic                          pt_dirty [NUM_PAGES];
   logic                          pt_refd  [NUM_PAGES];
   logic [pmmu_pkg::FRAME_W-1:0]  pt_frame [NUM_PAGES];
   logic [pmmu_pkg::FRAME_W-1:0]  frame_queue [NUM_FRAMES];
   int                            frames_loaded;
   logic                          policy_lru;
   logic [pmmu_pkg::FCOUNT_W-1:0] pool_count;
   logic [pmmu_pkg::FRAME_W-1:0]  pool_base;

   pmmu_pkg::rsp_word_type        pending_xlat [$];
   stim_row_type                  directed_rows [$];

   int mismatches = 0;
   int refs_sent = 0;
   int words_seen = 0;
   int faults_seen = 0;
   int writebacks_seen = 0;
   int csr_writes = 0;
   bit quiet = 1'b0;

   // a count of zero acts as one, anything above the maximum as the maximum
   function automatic int pool_frames();
      int n;
      n = int'(pool_count);
      if (n < 1) n = 1;
      if (n > NUM_FRAMES) n = NUM_FRAMES;
      return n;
   endfunction

   function automatic void rebuild_pool();
      for (int i = 0; i < NUM_PAGES; i++) begin
         pt_valid[i] = 1'b0;
         pt_dirty[i] = 1'b0;
         pt_refd[i]  = 1'b0;
         pt_frame[i] = '0;
      end
      for (int i = 0; i < NUM_FRAMES; i++)
         frame_queue[i] = pool_base + pmmu_pkg::FRAME_W'(i);
      frames_loaded = 0;
   endfunction

   function automatic void queue_to_back(int k, int n);
      logic [pmmu_pkg::FRAME_W-1:0] v;
      if (k >= n) return;
      v = frame_queue[k];
      for (int i = k; i + 1 < n; i++)
         frame_queue[i] = frame_queue[i + 1];
      frame_queue[n - 1] = v;
   endfunction

   function automatic void shadow_csr_write(logic [pmmu_pkg::CSR_AW-1:0] addr,
                                            logic [pmmu_pkg::CSR_DW-1:0] value);
      case (addr)
         ADDR_LRU_MODE: begin
            policy_lru = value[0];
         end
         ADDR_FRAME_COUNT: begin
            pool_count = value[pmmu_pkg::FCOUNT_W-1:0];
            rebuild_pool();
         end
         ADDR_FIRST_FRAME: begin
            pool_base = value[pmmu_pkg::FRAME_W-1:0];
            rebuild_pool();
         end
         default: ;
      endcase
   endfunction

   // translation of one reference, updating the shadow state
   function automatic pmmu_pkg::rsp_word_type translate_ref(pmmu_pkg::req_word_type w);
      pmmu_pkg::rsp_word_type       r;
      int                           page;
      int                           n;
      logic [pmmu_pkg::FRAME_W-1:0] taken;
      page = int'(w.logical_address[pmmu_pkg::ADDR_W-1:pmmu_pkg::OFFSET_W]) % NUM_PAGES;
      n = pool_frames();
      r = '0;
      if (pt_valid[page]) begin
         if (policy_lru) begin
            for (int i = 0; i < n; i++) begin
               if (frame_queue[i] == pt_frame[page]) begin
                  queue_to_back(i, n);
                  break;
               end
            end
         end
      end else begin
         taken = frame_queue[0];
         r.fault = 1'b1;
         queue_to_back(0, n);
         if (frames_loaded < n) begin
            frames_loaded++;
         end else begin
            // evict whichever page owns the head frame, if any
            for (int i = 0; i < NUM_PAGES; i++) begin
               if (pt_valid[i] && pt_frame[i] == taken) begin
                  pt_valid[i] = 1'b0;
                  r.dirty_evict = pt_dirty[i];
                  break;
               end
            end
         end
         pt_valid[page] = 1'b1;
         pt_frame[page] = taken;
         pt_dirty[page] = 1'b0;
         pt_refd[page]  = 1'b0;
      end
      pt_refd[page] = 1'b1;
      if (w.req_type == REQ_WRITE) pt_dirty[page] = 1'b1;
      r.physical_address = {pt_frame[page], w.logical_address[pmmu_pkg::OFFSET_W-1:0]};
      return r;
   endfunction

   // table building
   function automatic void add_ref(logic [pmmu_pkg::ADDR_W-1:0] la, logic kind, logic typed,
                                   logic pf, logic wb, logic [pmmu_pkg::PHYS_W-1:0] pa);
      stim_row_type row;
      row.kind = ROW_REF;
      row.csr_addr = '0;
      row.csr_value = '0;
      row.word.logical_address = la;
      row.word.req_type = kind;
      row.typed = typed;
      row.want.fault = pf;
      row.want.dirty_evict = wb;
      row.want.physical_address = pa;
      directed_rows.insert(directed_rows.size(), row);
   endfunction

   function automatic void add_csr(logic [pmmu_pkg::CSR_AW-1:0] addr,
                                   logic [pmmu_pkg::CSR_DW-1:0] value);
      stim_row_type row;
      row.kind = ROW_CSR;
      row.csr_addr = addr;
      row.csr_value = value;
      row.word = '0;
      row.typed = 1'b0;
      row.want = '0;
      directed_rows.insert(directed_rows.size(), row);
   endfunction

   // drive one reference word and hold it until the block takes it
   task automatic send_ref(pmmu_pkg::req_word_type w, logic typed,
                           pmmu_pkg::rsp_word_type want);
      pmmu_pkg::rsp_word_type p;
      start <= 1'b1;
      req_data <= w;
      @(posedge clock);
      while (busy) @(posedge clock);
      p = translate_ref(w);
      pending_xlat.insert(pending_xlat.size(), typed ? want : p);
      refs_sent++;
   endtask

   task automatic pause(int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // let every outstanding word come back before touching the csrs
   task automatic drain();
      start <= 1'b0;
      while (pending_xlat.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // write one register, then read it back through prdata
   task automatic csr_write(logic [pmmu_pkg::CSR_AW-1:0] addr,
                            logic [pmmu_pkg::CSR_DW-1:0] value);
      logic [pmmu_pkg::CSR_DW-1:0] rb_want;
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      shadow_csr_write(addr, value);
      csr_writes++;
      @(posedge clock);
      case (addr)
         ADDR_LRU_MODE:    rb_want = pmmu_pkg::CSR_DW'(policy_lru);
         ADDR_FRAME_COUNT: rb_want = pmmu_pkg::CSR_DW'(pool_count);
         ADDR_FIRST_FRAME: rb_want = pmmu_pkg::CSR_DW'(pool_base);
         default:          rb_want = '0;
      endcase
      if (prdata !== rb_want) begin
         if (mismatches < 10)
            $display("mismatch on register read at %0t: expected %h, got %h",
                     $realtime, rb_want, prdata);
         mismatches++;
      end
   endtask

   task automatic maybe_gap();
      if (!quiet && $urandom_range(0, 3) == 0) pause($urandom_range(1, 9));
   endtask

   function automatic void check_field(string name, logic [pmmu_pkg::PHYS_W-1:0] want,
                                       logic [pmmu_pkg::PHYS_W-1:0] got);
      if (want !== got) begin
         if (mismatches < 10)
            $display("mismatch on %s at %0t: expected %h, got %h", name, $realtime, want, got);
         mismatches++;
      end
   endfunction

   // result checker: every strobed word against the oldest expectation
   always @(posedge clock) begin : rsp_check
      pmmu_pkg::rsp_word_type want;
      if (!reset && rsp_valid) begin
         words_seen++;
         if (rsp_data.fault === 1'b1) faults_seen++;
         if (rsp_data.dirty_evict === 1'b1) writebacks_seen++;
         if (pending_xlat.size() == 0) begin
            if (mismatches < 10)
               $display("unexpected result word at %0t: %h", $realtime, rsp_data);
            mismatches++;
         end else begin
            want = pending_xlat.pop_front();
            check_field("fault", pmmu_pkg::PHYS_W'(want.fault),
                        pmmu_pkg::PHYS_W'(rsp_data.fault));
            check_field("dirty_evict", pmmu_pkg::PHYS_W'(want.dirty_evict),
                        pmmu_pkg::PHYS_W'(rsp_data.dirty_evict));
            check_field("physical_address", want.physical_address,
                        rsp_data.physical_address);
         end
      end
   end

   // watchdog
   initial begin
      #5ms;
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin : stimulus
      pmmu_pkg::req_word_type       w;
      pmmu_pkg::rsp_word_type       none;
      int                           ws;
      int                           ws_base;
      int                           page;
      int                           waited;
      logic                         lru_sel;
      logic [pmmu_pkg::CSR_DW-1:0]  fc_sel;
      logic [pmmu_pkg::CSR_DW-1:0]  ff_sel;

      none = '0;
      policy_lru = pmmu_pkg::RST_LRU_MODE;
      pool_count = pmmu_pkg::RST_FRAME_COUNT;
      pool_base  = pmmu_pkg::RST_FIRST_FRAME;
      rebuild_pool();

      // directed table: reset state, pool extremes, wrap, write-back, policies
      add_ref(16'h0000, REQ_READ,  1, 1, 0, 20'h40000);
      add_ref(16'h0ABC, REQ_WRITE, 1, 0, 0, 20'h40ABC);
      add_ref(16'hFFFF, REQ_WRITE, 1, 1, 0, 20'h41FFF);
      add_ref(16'hF000, REQ_READ,  1, 0, 0, 20'h41000);
      add_csr(ADDR_FRAME_COUNT, 32'd1);
      add_ref(16'h1234, REQ_WRITE, 1, 1, 0, 20'h40234);
      add_ref(16'h2345, REQ_READ,  1, 1, 1, 20'h40345);
      add_ref(16'h3000, REQ_READ,  1, 1, 0, 20'h40000);
      // zero frames behaves as one
      add_csr(ADDR_FRAME_COUNT, 32'd0);
      add_ref(16'h5FFF, REQ_WRITE, 1, 1, 0, 20'h40FFF);
      add_ref(16'h6001, REQ_READ,  1, 1, 1, 20'h40001);
      // oversized pool clamps, frame numbers wrap past 255
      add_csr(ADDR_FRAME_COUNT, 32'd31);
      add_csr(ADDR_FIRST_FRAME, 32'd255);
      add_ref(16'h7000, REQ_READ,  1, 1, 0, 20'hFF000);
      add_ref(16'h8000, REQ_READ,  1, 1, 0, 20'h00000);
      // write past the register list leaves the table alone
      add_csr(ADDR_UNMAPPED, 32'hFFFF_FFFF);
      add_ref(16'h7111, REQ_READ,  1, 0, 0, 20'hFF111);
      // small lru pool: hits reorder the queue
      add_csr(ADDR_LRU_MODE, 32'd1);
      add_csr(ADDR_FRAME_COUNT, 32'd2);
      add_csr(ADDR_FIRST_FRAME, 32'h10);
      add_ref(16'hA000, REQ_WRITE, 0, 0, 0, '0);
      add_ref(16'hB000, REQ_READ,  0, 0, 0, '0);
      add_ref(16'hA123, REQ_READ,  0, 0, 0, '0);
      add_ref(16'hC000, REQ_READ,  0, 0, 0, '0);
      add_ref(16'hD000, REQ_READ,  0, 0, 0, '0);
      add_ref(16'hE555, REQ_WRITE, 0, 0, 0, '0);
      // back to fifo on the same pool
      add_csr(ADDR_LRU_MODE, 32'd0);
      add_ref(16'hA000, REQ_WRITE, 0, 0, 0, '0);
      add_ref(16'hE000, REQ_READ,  0, 0, 0, '0);
      add_ref(16'hB000, REQ_READ,  0, 0, 0, '0);

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CSR) begin
            drain();
            csr_write(directed_rows[i].csr_addr, directed_rows[i].csr_value);
         end else begin
            send_ref(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].want);
            maybe_gap();
         end
      end

      // random phases, each under its own pool and policy
      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         quiet = (ph == RAND_PHASES - 1);
         case (ph)
            0: begin
               lru_sel = 1'b0; fc_sel = 32'd16; ff_sel = 32'd0;
            end
            1: begin
               lru_sel = 1'b1; fc_sel = 32'd1; ff_sel = 32'd255;
            end
            2: begin
               lru_sel = 1'b1; fc_sel = 32'd16; ff_sel = $urandom_range(0, 255);
            end
            default: begin
               lru_sel = 1'($urandom_range(0, 1));
               fc_sel = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31)
                                                    : $urandom_range(1, 16);
               ff_sel = $urandom_range(0, 255);
               // junk in the unused upper bits must be ignored
               if ($urandom_range(0, 1) == 1) begin
                  fc_sel = fc_sel | ($urandom & ~32'h1F);
                  ff_sel = ff_sel | ($urandom & ~32'hFF);
               end
            end
         endcase
         drain();
         csr_write(ADDR_LRU_MODE, {31'(lru_sel ? $urandom : 0) & ~31'h0, lru_sel});
         if ($urandom_range(0, 1) == 1) maybe_gap();
         csr_write(ADDR_FRAME_COUNT, fc_sel);
         csr_write(ADDR_FIRST_FRAME, ff_sel);

         // working set of random size at a random base (all pages in phase 0) so hits and evictions mix
         ws = (ph == 0) ? NUM_PAGES : $urandom_range(1, NUM_PAGES);
         ws_base = $urandom_range(0, NUM_PAGES - 1);
         for (int k = 0; k < REFS_PER_PHASE; k++) begin
            if ($urandom_range(0, 3) == 0) page = $urandom_range(0, NUM_PAGES - 1);
            else page = (ws_base + $urandom_range(0, ws - 1)) % NUM_PAGES;
            w.logical_address = {4'(page), 12'($urandom)};
            w.req_type = 1'($urandom_range(0, 1));
            send_ref(w, 1'b0, none);
            maybe_gap();
         end
      end
      start <= 1'b0;

      // wait for the tail of the results
      waited = 0;
      while (pending_xlat.size() != 0 && waited < 1000) begin
         @(posedge clock);
         waited++;
      end
      repeat (5) @(posedge clock);
      if (pending_xlat.size() != 0) begin
         $display("%0d result words never arrived", pending_xlat.size());
         mismatches += pending_xlat.size();
      end

      $display("covered %0d references in %0d pool settings (%0d csr writes)",
               refs_sent, RAND_PHASES + 5, csr_writes);
      $display("saw %0d result words, %0d page faults, %0d write-backs, %0d mismatches",
               words_seen, faults_seen, writebacks_seen, mismatches);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
